// ----- rtl/ptc_pkg.sv -----
// Shared types, register map and codes for the pretrigger trace capture block.
package ptc_pkg;

  // Default ring depth in samples
  localparam int DEPTH_DEF = 32;

  // Configuration port geometry
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_TRIGGER  = 2'd1;
  localparam logic [1:0] REG_PRETRIG  = 2'd2;
  localparam logic [1:0] REG_AMP_CHAN = 2'd3;

  // Sampling modes
  localparam logic [1:0] MODE_DISABLED = 2'd0;
  localparam logic [1:0] MODE_PEAK     = 2'd1;
  localparam logic [1:0] MODE_TRACE    = 2'd2;
  localparam logic [1:0] MODE_INVALID  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_REPORT  = 2'd0;
  localparam logic [1:0] KIND_TRACE   = 2'd1;
  localparam logic [1:0] KIND_REQUEST = 2'd2;

  // Input commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_EVENT  = 1'b1;

  // Reset value of the pretrigger count
  localparam logic [5:0] PRETRIG_RST = 6'd8;

  typedef struct packed {
    logic               cmd;
    logic [1:0]         sample_channel;
    logic signed [15:0] sample_code;
    logic [7:0]         event_signal;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         out_channel;
    logic signed [15:0] out_code;
    logic               last;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic read;
    logic load;
  } ptc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic dump_req;
    logic last_elem;
  } ptc_sts_t;

endpackage

// ----- rtl/pretrigger_trace_capture.sv -----
// Pretrigger trace capture: amplitude samples kept in a ring and dumped around a trigger.
// An item that yields at most one result is accepted whenever the output register is
// empty or being emptied in that cycle. An amplitude sample that completes a trace
// capture starts a dump of the ring, oldest entry first: each stored entry is read from
// the ring RAM and then loaded into the output register, the load waiting while the
// output is stalled, and no item is accepted until the last element is loaded. A sample
// report that the same item causes comes out before the dump. Registers sit at byte
// addresses 0 (mode), 4 (trigger signal), 8 (pretrigger count) and 12 (amplitude
// channel); writing a valid mode empties the ring and stops capture. Write registers
// only while idle.
module pretrigger_trace_capture import ptc_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item
);

  ptc_cmd_t cmd;
  ptc_sts_t sts;

  ptc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptc_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- rtl/ptc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ptc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/ptc_datapath.sv -----
// Datapath: configuration registers, ring pointers, ring RAM and output register.
module ptc_datapath import ptc_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // channels
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item,
  // control
  input  ptc_cmd_t          cmd,
  output ptc_sts_t          sts
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Configuration
  logic [1:0] mode_r;
  logic [7:0] trig_r;
  logic [5:0] pretrig_r;
  logic [1:0] amp_r;

  // Capture state
  logic [PW-1:0] wp_r;
  logic [CW-1:0] fill_r;
  logic          cap_r;
  logic [CW-1:0] post_r;

  // Dump sequencing
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] rem_r;

  // Output register
  logic      out_valid_r;
  out_item_t out_item_r;

  logic          cfg_wr;
  logic          is_amp;
  logic          trig_hit;
  logic          trace_smp;
  logic [PW-1:0] wp_inc;
  logic [CW-1:0] fill_inc;
  logic [CW-1:0] pre_sat;
  logic [CW-1:0] thr;
  logic [CW-1:0] post_inc;
  logic          dump_hit;
  logic [CW:0]   start_sum;
  logic [PW-1:0] start_ptr;
  logic [PW-1:0] rd_ptr_inc;
  logic          emit;
  out_item_t     res;
  logic [15:0]   ram_rdata;

  assign cfg_wr    = psel & penable & pwrite;
  assign pready    = 1'b1;
  assign is_amp    = (in_item.sample_channel == amp_r);
  assign trig_hit  = (in_item.event_signal == trig_r);
  assign trace_smp = (in_item.cmd == CMD_SAMPLE) && is_amp && (mode_r == MODE_TRACE);

  // Advance write pointer and fill level for a new ring entry
  assign wp_inc   = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign fill_inc = (fill_r == CW'(DEPTH)) ? fill_r : fill_r + 1'b1;

  // Post-trigger threshold, pretrigger saturated at the ring depth
  assign pre_sat  = (int'(pretrig_r) > DEPTH) ? CW'(DEPTH) : CW'(pretrig_r);
  assign thr      = CW'(DEPTH) - pre_sat;
  assign post_inc = post_r + 1'b1;
  assign dump_hit = trace_smp && cap_r && (post_inc >= thr);

  // Oldest entry after this sample is written
  assign start_sum = (CW + 1)'(wp_inc) + (CW + 1)'(DEPTH) - (CW + 1)'(fill_inc);
  assign start_ptr = (start_sum >= (CW + 1)'(DEPTH)) ?
                     PW'(start_sum - (CW + 1)'(DEPTH)) : PW'(start_sum);

  assign rd_ptr_inc = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  // Single result an accepted item can produce directly
  always_comb begin
    emit = 1'b0;
    res  = '0;
    if (in_item.cmd == CMD_EVENT) begin
      if (trig_hit && (mode_r != MODE_DISABLED)) begin
        emit            = 1'b1;
        res.kind        = KIND_REQUEST;
        res.out_channel = amp_r;
      end
    end else if (!is_amp || (mode_r == MODE_PEAK) ||
                 (trace_smp && cap_r && (post_r == '0))) begin
      emit            = 1'b1;
      res.kind        = KIND_REPORT;
      res.out_channel = in_item.sample_channel;
      res.out_code    = in_item.sample_code;
    end
  end

  // Configuration and capture state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_DISABLED;
      trig_r    <= '0;
      pretrig_r <= PRETRIG_RST;
      amp_r     <= '0;
      wp_r      <= '0;
      fill_r    <= '0;
      cap_r     <= 1'b0;
      post_r    <= '0;
      rd_ptr_r  <= '0;
      rem_r     <= '0;
    end else begin
      // update capture state for an accepted item
      if (cmd.accept) begin
        if (in_item.cmd == CMD_EVENT) begin
          if (trig_hit) begin
            cap_r  <= 1'b1;
            post_r <= '0;
          end
        end else if (is_amp) begin
          if (mode_r == MODE_TRACE) begin
            wp_r   <= wp_inc;
            fill_r <= fill_inc;
            if (cap_r) begin
              if (dump_hit) begin
                cap_r    <= 1'b0;
                post_r   <= '0;
                rd_ptr_r <= start_ptr;
                rem_r    <= fill_inc;
              end else begin
                post_r <= post_inc;
              end
            end
          end else if (mode_r == MODE_PEAK) begin
            cap_r  <= 1'b1;
            post_r <= '0;
          end
        end
      end
      // step through the ring during a dump
      if (cmd.read) begin
        rd_ptr_r <= rd_ptr_inc;
      end
      if (cmd.load) begin
        rem_r <= rem_r - 1'b1;
      end
      // register writes
      if (cfg_wr) begin
        unique case (paddr[ADDR_W-1:2])
          REG_MODE: begin
            if (pwdata[1:0] != MODE_INVALID) begin
              mode_r <= pwdata[1:0];
              wp_r   <= '0;
              fill_r <= '0;
              cap_r  <= 1'b0;
              post_r <= '0;
            end
          end
          REG_TRIGGER:  trig_r    <= pwdata[7:0];
          REG_PRETRIG:  pretrig_r <= pwdata[5:0];
          REG_AMP_CHAN: amp_r     <= pwdata[1:0];
          default: ;
        endcase
      end
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_MODE:     prdata = DATA_W'(mode_r);
      REG_TRIGGER:  prdata = DATA_W'(trig_r);
      REG_PRETRIG:  prdata = DATA_W'(pretrig_r);
      REG_AMP_CHAN: prdata = DATA_W'(amp_r);
      default:      prdata = '0;
    endcase
  end

  // Ring memory
  ptc_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (cmd.accept && trace_smp),
    .wr_addr (wp_r),
    .wr_data (in_item.sample_code),
    .rd_en   (cmd.read),
    .rd_addr (rd_ptr_r),
    .rd_data (ram_rdata)
  );

  // Output valid: load on a result, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.accept && emit) || cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.accept && emit) begin
      out_item_r <= res;
    end else if (cmd.load) begin
      out_item_r.kind        <= KIND_TRACE;
      out_item_r.out_channel <= amp_r;
      out_item_r.out_code    <= $signed(ram_rdata);
      out_item_r.last        <= (rem_r == CW'(1));
    end
  end

  assign out_valid     = out_valid_r;
  assign out_item      = out_item_r;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.dump_req  = dump_hit;
  assign sts.last_elem = (rem_r == CW'(1));

endmodule

// ----- rtl/ptc_ctrl.sv -----
// Controller: accepts items and sequences the trace dump out of the ring.
module ptc_ctrl import ptc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ptc_sts_t sts,
  output ptc_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Decode commands from state
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    state_nxt  = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = sts.out_free;
        cmd.accept = in_valid && sts.out_free;
        if (cmd.accept && sts.dump_req) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = sts.last_elem ? S_IDLE : S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- bench/ptc_result_checker.sv -----
// Result checker for the pretrigger trace capture block: shadow model, expected queue, compare.
`timescale 1ns / 1ps

module ptc_result_checker import ptc_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_item_t          in_item,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_item_t         out_item,
  output int                error_count,
  output int                results_due
);

  localparam int PW = $clog2(DEPTH);

  // Shadow copy of the configuration registers
  logic [1:0] mode;
  logic [7:0] trig_sig;
  logic [5:0] pretrig;
  logic [1:0] amp_ch;

  // Shadow copy of the capture state
  logic [15:0] ring_q [DEPTH];
  int          wr_ptr;
  int          fill;
  bit          armed;
  int          post_cnt;

  out_item_t due_results[$];
  int        errs;

  initial begin
    errs = 0;
  end

  // Empty the ring and stop capture
  task automatic clear_capture();
    wr_ptr = 0;
    fill = 0;
    armed = 1'b0;
    post_cnt = 0;
  endtask

  // Append one expected result at the tail of the queue
  task automatic queue_result(input out_item_t r);
    due_results.insert(due_results.size(), r);
  endtask

  function automatic out_item_t mk_result(input logic [1:0] kind, input logic [1:0] ch,
                                          input logic [15:0] code, input logic last);
    out_item_t r;
    r.kind = kind;
    r.out_channel = ch;
    r.out_code = code;
    r.last = last;
    return r;
  endfunction

  // Work out the results that one accepted item causes
  task automatic capture_step(input in_item_t it);
    int pre;
    int thresh;
    int start;
    int i;
    if (it.cmd == CMD_EVENT) begin
      if (it.event_signal == trig_sig) begin
        armed = 1'b1;
        post_cnt = 0;
        if (mode != MODE_DISABLED)
          queue_result(mk_result(KIND_REQUEST, amp_ch, 16'd0, 1'b0));
      end
    end else if (it.sample_channel != amp_ch) begin
      queue_result(mk_result(KIND_REPORT, it.sample_channel, it.sample_code, 1'b0));
    end else if (mode == MODE_TRACE) begin
      pre = (pretrig > DEPTH) ? DEPTH : int'(pretrig);
      thresh = DEPTH - pre;
      ring_q[PW'(wr_ptr)] = it.sample_code;
      wr_ptr = (wr_ptr + 1) % DEPTH;
      if (fill < DEPTH)
        fill++;
      // First sample after the trigger is reported ahead of any dump
      if (armed && post_cnt == 0)
        queue_result(mk_result(KIND_REPORT, it.sample_channel, it.sample_code, 1'b0));
      if (armed) begin
        post_cnt++;
        if (post_cnt >= thresh) begin
          // Dump the ring, oldest entry first
          start = (wr_ptr + DEPTH - fill) % DEPTH;
          for (i = 0; i < fill; i++)
            queue_result(mk_result(KIND_TRACE, amp_ch, ring_q[PW'((start + i) % DEPTH)],
                                   (i + 1 == fill)));
          armed = 1'b0;
          post_cnt = 0;
        end
      end
    end else if (mode == MODE_PEAK) begin
      queue_result(mk_result(KIND_REPORT, it.sample_channel, it.sample_code, 1'b0));
      armed = 1'b1;
      post_cnt = 0;
    end
  endtask

  // Watch the ports, track registers, predict and compare
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      mode = MODE_DISABLED;
      trig_sig = 8'd0;
      pretrig = PRETRIG_RST;
      amp_ch = 2'd0;
      clear_capture();
      due_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MODE: begin
            if (pwdata[1:0] != MODE_INVALID) begin
              mode = pwdata[1:0];
              clear_capture();
            end
          end
          REG_TRIGGER:  trig_sig = pwdata[7:0];
          REG_PRETRIG:  pretrig = pwdata[5:0];
          REG_AMP_CHAN: amp_ch = pwdata[1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          if (errs < 10)
            $display("%0t: unexpected item kind=%0d ch=%0d code=%h last=%0d",
                     $realtime, out_item.kind, out_item.out_channel,
                     out_item.out_code, out_item.last);
          errs++;
        end else begin
          want = due_results[0];
          due_results.delete(0);
          if (want.kind !== out_item.kind || want.out_channel !== out_item.out_channel ||
              want.out_code !== out_item.out_code || want.last !== out_item.last) begin
            if (errs < 10)
              $display({"%0t: mismatch exp kind=%0d ch=%0d code=%h last=%0d,",
                        " got kind=%0d ch=%0d code=%h last=%0d"},
                       $realtime, want.kind, want.out_channel, want.out_code, want.last,
                       out_item.kind, out_item.out_channel, out_item.out_code,
                       out_item.last);
            errs++;
          end
        end
      end
      if (in_valid && in_ready)
        capture_step(in_item);
    end
    error_count <= errs;
    results_due <= due_results.size();
  end

endmodule

// ----- bench/pretrigger_trace_capture_tb.sv -----
// Top of the pretrigger trace capture testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module pretrigger_trace_capture_tb;
  import ptc_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_item = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_item;

  int error_count;
  int results_due;
  int send_idle_pct = 15;
  int recv_idle_pct = 45;

  // Stimulus-side copy of the settings
  logic [7:0] cur_trig;
  logic [5:0] cur_pretrig;
  logic [1:0] cur_amp;

  pretrigger_trace_capture #(.DEPTH(DEPTH_DEF)) dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  ptc_result_checker #(.DEPTH(DEPTH_DEF)) u_check (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .error_count(error_count), .results_due(results_due)
  );

  always #5 clk = ~clk;

  // Stall the result side at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Bound the run
  initial begin
    #5_000_000;
    $display("pretrigger_trace_capture regression: fail");
    $finish;
  end

  // Setup cycle, then access cycle; register is written at the end of the access
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_TRIGGER) cur_trig = value[7:0];
    if (idx == REG_PRETRIG) cur_pretrig = value[5:0];
    if (idx == REG_AMP_CHAN) cur_amp = value[1:0];
    @(posedge clk);
  endtask

  // Hold off the sender until every expected result is out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic in_item_t sample_item(input logic [1:0] ch, input logic [15:0] code);
    in_item_t it;
    it.cmd = CMD_SAMPLE;
    it.sample_channel = ch;
    it.sample_code = code;
    it.event_signal = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic in_item_t event_item(input logic [7:0] sig);
    in_item_t it;
    it.cmd = CMD_EVENT;
    it.sample_channel = 2'($urandom_range(0, 3));
    it.sample_code = 16'($urandom_range(0, 65535));
    it.event_signal = sig;
    return it;
  endfunction

  // Pick a setting for one random phase; the mode write goes last since it clears capture
  task automatic configure_random(input int ph);
    int r;
    logic [1:0] m;
    logic [5:0] p;
    r = $urandom_range(0, 3);
    cfg_write(REG_TRIGGER, (r == 0) ? 32'd0 : (r == 1) ? 32'd255 : $urandom_range(0, 255));
    r = $urandom_range(0, 6);
    case (r)
      0: p = 6'd0;
      1: p = 6'd32;
      2: p = 6'd63;
      3: p = 6'd31;
      default: p = 6'($urandom_range(20, 40));
    endcase
    r = $urandom_range(0, 9);
    m = (r == 0) ? MODE_DISABLED : (r < 3) ? MODE_PEAK : MODE_TRACE;
    // Force a full-depth post-trigger capture once
    if (ph == 2) begin
      p = 6'd0;
      m = MODE_TRACE;
    end
    cfg_write(REG_PRETRIG, 32'(p));
    cfg_write(REG_AMP_CHAN, $urandom_range(0, 3));
    cfg_write(REG_MODE, 32'(m));
    if ($urandom_range(0, 2) == 0)
      cfg_write(REG_MODE, 32'(MODE_INVALID));
  endtask

  // Mostly amplitude samples with triggers among them; the rest is noise
  task automatic run_items(input int count, input int amp_pct);
    int i;
    int r;
    int rest;
    in_item_t it;
    rest = (100 - amp_pct) / 3;
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < amp_pct)
        it = sample_item(cur_amp, 16'($urandom_range(0, 65535)));
      else if (r < amp_pct + rest)
        it = sample_item(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
      else if (r < amp_pct + 2 * rest)
        it = event_item(cur_trig);
      else
        it = event_item(8'($urandom_range(0, 255)));
      send_item(it);
    end
  endtask

  initial begin : stimulus
    int ph;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Trace mode: pass-through, fill, trigger, dump after two samples
    cfg_write(REG_MODE, 32'(MODE_TRACE));
    cfg_write(REG_TRIGGER, 32'hFF);
    cfg_write(REG_PRETRIG, 32'd30);
    cfg_write(REG_AMP_CHAN, 32'd1);
    send_item(sample_item(2'd0, 16'h7FFF));
    send_item(sample_item(2'd3, 16'h8000));
    send_item(event_item(8'h00));
    send_item(sample_item(2'd1, 16'h8000));
    send_item(sample_item(2'd1, 16'h7FFF));
    send_item(sample_item(2'd1, 16'h0000));
    send_item(event_item(8'hFF));
    send_item(sample_item(2'd1, 16'hFFFF));
    send_item(sample_item(2'd1, 16'h1234));

    // Invalid mode leaves the ring alone; oversized pretrigger dumps at once
    drain();
    cfg_write(REG_MODE, 32'(MODE_INVALID));
    cfg_write(REG_PRETRIG, 32'd40);
    cfg_write(REG_TRIGGER, 32'h00);
    send_item(event_item(8'h00));
    send_item(sample_item(2'd1, 16'h5555));

    // Peak mode
    drain();
    cfg_write(REG_MODE, 32'(MODE_PEAK));
    cfg_write(REG_AMP_CHAN, 32'd2);
    send_item(sample_item(2'd2, 16'h8001));
    send_item(sample_item(2'd1, 16'hAAAA));
    send_item(event_item(8'h00));

    // Disabled mode: amplitude samples and triggers yield nothing
    drain();
    cfg_write(REG_MODE, 32'(MODE_DISABLED));
    cfg_write(REG_PRETRIG, 32'd0);
    cfg_write(REG_AMP_CHAN, 32'd3);
    send_item(sample_item(2'd3, 16'h7FFF));
    send_item(event_item(8'h00));
    send_item(sample_item(2'd0, 16'h0001));

    // Trace with the whole ring ahead of the trigger
    drain();
    cfg_write(REG_PRETRIG, 32'd32);
    cfg_write(REG_MODE, 32'(MODE_TRACE));
    send_item(sample_item(2'd3, 16'h7FFF));
    send_item(event_item(8'h00));
    send_item(sample_item(2'd3, 16'h8000));

    // Random phases under changing settings and idling
    for (ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 45;
        recv_idle_pct = 15;
      end
      if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain();
      configure_random(ph);
      if (cur_pretrig < 16)
        run_items(40, 90);
      else
        run_items(22, 60);
    end

    drain();
    repeat (2 * DEPTH_DEF + 8) @(posedge clk);
    if (error_count == 0)
      $display("pretrigger_trace_capture regression: pass");
    else
      $display("pretrigger_trace_capture regression: fail");
    $finish;
  end

endmodule
